// ----- design/oqpm_pkg.sv -----
// ---------------------------------------------------------------------------
// oqpm_pkg
// Shared types and codes for the ordered queue with position map.
// ---------------------------------------------------------------------------
package oqpm_pkg;

  localparam int ID_W     = 6;
  localparam int TGT_W    = 5;
  localparam int OPOS_W   = 6;

  typedef enum logic [1:0] {
    REQ_APPEND,
    REQ_REMOVE,
    REQ_MOVE,
    REQ_QUERY
  } req_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_QUEUED,
    ST_UNCHANGED,
    ST_FULL,
    ST_ALREADY
  } status_t;

  typedef struct packed {
    req_t             req_type;
    logic [ID_W-1:0]  item_id;
    logic [TGT_W-1:0] target_pos;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [OPOS_W-1:0] position;
    logic [ID_W-1:0]   moved_id;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_RD,
    S_WR,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    RES_NQ,
    RES_ALREADY,
    RES_FULL,
    RES_APPEND,
    RES_QUERY,
    RES_UNCHANGED,
    RES_REMOVE,
    RES_HEAD,
    RES_STEP,
    RES_TAIL
  } res_t;

  typedef struct packed {
    logic take;
    logic look;
    logic append;
    logic rd;
    logic step;
    logic fin;
    logic emit;
    res_t res;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic in_range;
    logic hit;
    logic full;
    logic same;
    logic down;
    logic up;
    logic more;
    logic out_free;
  } stat_t;

endpackage

// ----- design/oqpm_dp.sv -----
// ---------------------------------------------------------------------------
// oqpm_dp
// Datapath: order memory, position table with valid bits, length, walk
// counter and the output register.
// ---------------------------------------------------------------------------
module oqpm_dp #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_COUNT    = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  oqpm_pkg::in_item_t in_data,
  input  oqpm_pkg::cmd_t     cmd,
  output oqpm_pkg::stat_t    stat,
  output logic               out_valid,
  input  logic               out_stall,
  output oqpm_pkg::out_item_t out_data
);

  localparam int TBL = (ID_COUNT < 64) ? ID_COUNT : 64;
  localparam int TW  = $clog2(TBL);
  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int PW  = $clog2(QUEUE_DEPTH + 1);
  localparam int IW  = oqpm_pkg::ID_W;

  oqpm_pkg::req_t            req_r;
  logic [IW-1:0]             id_r;
  logic [oqpm_pkg::TGT_W-1:0] tgt_r;
  logic [PW-1:0]             len;
  logic [PW-1:0]             pos_r;
  logic [PW-1:0]             t_r;
  logic [PW-1:0]             k;
  logic                      up_r;
  logic [IW-1:0]             carry;

  logic [IW-1:0]             order_mem [QUEUE_DEPTH];
  logic [IW-1:0]             ord_q;
  logic [AW-1:0]             tbl_mem [TBL];
  logic [AW-1:0]             tbl_q;
  logic [TBL-1:0]            vld;
  logic                      vld_q;

  logic                      in_range;
  logic                      hit;
  logic [PW-1:0]             tbl_pos;
  logic [PW-1:0]             pos_c;
  logic [PW-1:0]             t_c;
  logic [TW-1:0]             tidx;
  logic                      out_free;

  logic                      ord_we;
  logic [AW-1:0]             ord_wa;
  logic [IW-1:0]             ord_wd;
  logic                      tbl_we;
  logic                      tbl_set;
  logic [TW-1:0]             tbl_wa;
  logic [AW-1:0]             tbl_wd;

  oqpm_pkg::out_item_t       res_val;
  logic [PW-1:0]             step_pos;

  // lookup
  assign tidx     = id_r[TW-1:0];
  assign in_range = 32'(id_r) < ID_COUNT;
  assign tbl_pos  = PW'(tbl_q);
  assign hit      = in_range && vld_q && (tbl_pos < len);
  assign pos_c    = hit ? tbl_pos : PW'(QUEUE_DEPTH);
  assign t_c      = (32'(tgt_r) >= 32'(len)) ? (len - PW'(1)) : PW'(tgt_r);
  assign out_free = !out_valid || !out_stall;
  assign step_pos = up_r ? (k + PW'(1)) : (k - PW'(1));

  always_comb begin
    stat.req      = req_r;
    stat.in_range = in_range;
    stat.hit      = hit;
    stat.full     = len >= PW'(QUEUE_DEPTH);
    stat.same     = t_c == pos_c;
    stat.down     = pos_c < t_c;
    stat.up       = up_r;
    stat.out_free = out_free;
    if (req_r == oqpm_pkg::REQ_REMOVE) begin
      stat.more = k < len;
    end else if (up_r) begin
      stat.more = k < pos_r;
    end else begin
      stat.more = k <= t_r;
    end
  end

  // memory write selection
  always_comb begin
    ord_we  = 1'b0;
    ord_wa  = '0;
    ord_wd  = '0;
    tbl_we  = 1'b0;
    tbl_set = 1'b1;
    tbl_wa  = '0;
    tbl_wd  = '0;
    if (cmd.append) begin
      ord_we = 1'b1;
      ord_wa = AW'(len);
      ord_wd = id_r;
      tbl_we = 1'b1;
      tbl_wa = tidx;
      tbl_wd = AW'(len);
    end else if (cmd.step) begin
      ord_we = 1'b1;
      ord_wa = up_r ? AW'(k) : AW'(k - PW'(1));
      ord_wd = up_r ? carry : ord_q;
      tbl_we = 1'b1;
      tbl_wa = ord_q[TW-1:0];
      tbl_wd = AW'(step_pos);
    end else if (cmd.fin) begin
      tbl_we = 1'b1;
      tbl_wa = tidx;
      if (req_r == oqpm_pkg::REQ_REMOVE) begin
        tbl_set = 1'b0;
      end else begin
        ord_we = 1'b1;
        ord_wa = up_r ? AW'(pos_r) : AW'(t_r);
        ord_wd = up_r ? carry : id_r;
        tbl_wd = AW'(t_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_wa] <= ord_wd;
    end
    if (cmd.rd) begin
      ord_q <= order_mem[AW'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we && tbl_set) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (cmd.take) begin
      tbl_q <= tbl_mem[in_data.item_id[TW-1:0]];
      vld_q <= vld[in_data.item_id[TW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (tbl_we) begin
      vld[tbl_wa] <= tbl_set;
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_r <= in_data.req_type;
      id_r  <= in_data.item_id;
      tgt_r <= in_data.target_pos;
    end
    if (cmd.look) begin
      pos_r <= pos_c;
      t_r   <= t_c;
      up_r  <= (req_r == oqpm_pkg::REQ_MOVE) && (t_c < pos_c);
      carry <= id_r;
      k     <= ((req_r == oqpm_pkg::REQ_MOVE) && (t_c < pos_c)) ? t_c : (pos_c + PW'(1));
    end else if (cmd.step) begin
      k <= k + PW'(1);
      if (up_r) begin
        carry <= ord_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.append) begin
      len <= len + PW'(1);
    end else if (cmd.fin && req_r == oqpm_pkg::REQ_REMOVE) begin
      len <= len - PW'(1);
    end
  end

  // result selection
  always_comb begin
    res_val.status   = oqpm_pkg::ST_OK;
    res_val.position = oqpm_pkg::OPOS_W'(pos_c);
    res_val.moved_id = '0;
    res_val.last     = 1'b1;
    unique case (cmd.res)
      oqpm_pkg::RES_NQ: begin
        res_val.status   = oqpm_pkg::ST_NOT_QUEUED;
        res_val.position = oqpm_pkg::OPOS_W'(QUEUE_DEPTH);
      end
      oqpm_pkg::RES_ALREADY: begin
        res_val.status = oqpm_pkg::ST_ALREADY;
      end
      oqpm_pkg::RES_FULL: begin
        res_val.status   = oqpm_pkg::ST_FULL;
        res_val.position = oqpm_pkg::OPOS_W'(QUEUE_DEPTH);
      end
      oqpm_pkg::RES_APPEND: begin
        res_val.position = oqpm_pkg::OPOS_W'(len);
      end
      oqpm_pkg::RES_QUERY: begin
        res_val.status = oqpm_pkg::ST_OK;
      end
      oqpm_pkg::RES_UNCHANGED: begin
        res_val.status = oqpm_pkg::ST_UNCHANGED;
      end
      oqpm_pkg::RES_REMOVE: begin
        res_val.position = oqpm_pkg::OPOS_W'(pos_r);
      end
      oqpm_pkg::RES_HEAD: begin
        res_val.position = oqpm_pkg::OPOS_W'(t_c);
        res_val.moved_id = id_r;
        res_val.last     = 1'b0;
      end
      oqpm_pkg::RES_STEP: begin
        res_val.position = oqpm_pkg::OPOS_W'(step_pos);
        res_val.moved_id = ord_q;
        res_val.last     = !up_r && (k == t_r);
      end
      oqpm_pkg::RES_TAIL: begin
        res_val.position = oqpm_pkg::OPOS_W'(t_r);
        res_val.moved_id = id_r;
      end
      default: begin
        res_val.status = oqpm_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= res_val;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= PW'(QUEUE_DEPTH))
    else $error("queue length beyond depth");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.append |=> len == $past(len) + PW'(1))
    else $error("append did not grow the queue");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin && req_r == oqpm_pkg::REQ_REMOVE) |=> len == $past(len) - PW'(1))
    else $error("remove did not shrink the queue");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result written over a waiting beat");

endmodule

// ----- design/oqpm_ctrl.sv -----
// ---------------------------------------------------------------------------
// oqpm_ctrl
// Request sequencer: lookup, decision, shift walk and final update.
// ---------------------------------------------------------------------------
module oqpm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  oqpm_pkg::stat_t stat,
  output oqpm_pkg::cmd_t  cmd
);

  oqpm_pkg::state_t state;
  oqpm_pkg::state_t state_next;
  logic             simple;

  assign simple = (stat.req == oqpm_pkg::REQ_APPEND) || (stat.req == oqpm_pkg::REQ_QUERY)
                  || !stat.hit || ((stat.req == oqpm_pkg::REQ_MOVE) && stat.same);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oqpm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      oqpm_pkg::S_IDLE: begin
        if (in_valid) state_next = oqpm_pkg::S_LOOK;
      end
      oqpm_pkg::S_LOOK: begin
        if (stat.out_free) state_next = simple ? oqpm_pkg::S_IDLE : oqpm_pkg::S_RD;
      end
      oqpm_pkg::S_RD: begin
        state_next = stat.more ? oqpm_pkg::S_WR : oqpm_pkg::S_FIN;
      end
      oqpm_pkg::S_WR: begin
        if (stat.req == oqpm_pkg::REQ_REMOVE || stat.out_free) state_next = oqpm_pkg::S_RD;
      end
      oqpm_pkg::S_FIN: begin
        if (!(stat.req == oqpm_pkg::REQ_REMOVE || stat.up) || stat.out_free) begin
          state_next = oqpm_pkg::S_IDLE;
        end
      end
      default: state_next = oqpm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.res  = oqpm_pkg::RES_NQ;
    in_stall = state != oqpm_pkg::S_IDLE;
    unique case (state)
      oqpm_pkg::S_IDLE: begin
        cmd.take = in_valid;
      end
      oqpm_pkg::S_LOOK: begin
        if (stat.out_free) begin
          unique case (stat.req)
            oqpm_pkg::REQ_APPEND: begin
              cmd.emit = 1'b1;
              if (!stat.in_range) begin
                cmd.res = oqpm_pkg::RES_NQ;
              end else if (stat.hit) begin
                cmd.res = oqpm_pkg::RES_ALREADY;
              end else if (stat.full) begin
                cmd.res = oqpm_pkg::RES_FULL;
              end else begin
                cmd.res    = oqpm_pkg::RES_APPEND;
                cmd.append = 1'b1;
              end
            end
            oqpm_pkg::REQ_QUERY: begin
              cmd.emit = 1'b1;
              cmd.res  = stat.hit ? oqpm_pkg::RES_QUERY : oqpm_pkg::RES_NQ;
            end
            oqpm_pkg::REQ_REMOVE: begin
              if (!stat.hit) begin
                cmd.emit = 1'b1;
              end else begin
                cmd.look = 1'b1;
              end
            end
            oqpm_pkg::REQ_MOVE: begin
              if (!stat.hit) begin
                cmd.emit = 1'b1;
              end else if (stat.same) begin
                cmd.emit = 1'b1;
                cmd.res  = oqpm_pkg::RES_UNCHANGED;
              end else begin
                cmd.look = 1'b1;
                cmd.emit = stat.down;
                cmd.res  = oqpm_pkg::RES_HEAD;
              end
            end
            default: cmd.emit = 1'b1;
          endcase
        end
      end
      oqpm_pkg::S_RD: begin
        cmd.rd = stat.more;
      end
      oqpm_pkg::S_WR: begin
        if (stat.req == oqpm_pkg::REQ_REMOVE) begin
          cmd.step = 1'b1;
        end else if (stat.out_free) begin
          cmd.step = 1'b1;
          cmd.emit = 1'b1;
          cmd.res  = oqpm_pkg::RES_STEP;
        end
      end
      oqpm_pkg::S_FIN: begin
        if (stat.req == oqpm_pkg::REQ_REMOVE) begin
          cmd.fin  = stat.out_free;
          cmd.emit = stat.out_free;
          cmd.res  = oqpm_pkg::RES_REMOVE;
        end else if (stat.up) begin
          cmd.fin  = stat.out_free;
          cmd.emit = stat.out_free;
          cmd.res  = oqpm_pkg::RES_TAIL;
        end else begin
          cmd.fin = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == oqpm_pkg::S_LOOK)
    else $error("accepted beat not looked up");

  a_step_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> state == oqpm_pkg::S_WR)
    else $error("order read not followed by write step");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> state == oqpm_pkg::S_IDLE)
    else $error("final update did not end the request");

endmodule

// ----- design/ordered_queue_with_position_map_unit.sv -----
// ---------------------------------------------------------------------------
// ordered_queue_with_position_map_unit
// Ordered queue of ids with a reverse map from id to position.
//
//   channel  dir  payload     handshake
//   in       in   in_item_t   in_valid / in_stall
//   out      out  out_item_t  out_valid / out_stall
//
// append, query and rejected requests: the input beat is registered with its
// table lookup, the result is registered in the output register from S_LOOK,
// and the next input beat is taken once the unit is back in S_IDLE.
// remove and move walk the order memory one entry at a time, a read (S_RD)
// then a write (S_WR), over the entries from the lower position to the
// higher one (to the end for remove).
// reset clears length and map valid bits at once, no clearing pass.
// a waiting result beat holds each lookup; the walk only when a result is due.
// ---------------------------------------------------------------------------
module ordered_queue_with_position_map_unit #(
  parameter int QUEUE_DEPTH = 32,
  parameter int ID_COUNT    = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  oqpm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output oqpm_pkg::out_item_t out_data
);

  oqpm_pkg::cmd_t  cmd;
  oqpm_pkg::stat_t stat;

  oqpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  oqpm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_COUNT    (ID_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Checks the ordered queue with position map against its own queue and
// position table. Requests are fed in random bursts, results are taken
// under a random stall pattern and compared beat by beat in order.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int IDS   = 64;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  oqpm_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  oqpm_pkg::out_item_t out_data;

  ordered_queue_with_position_map_unit DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  oqpm_pkg::in_item_t  pending_reqs[$];
  oqpm_pkg::out_item_t expected_beats[$];
  int                  slot_ids[DEPTH];
  int                  id_pos[IDS];
  int                  qlen;
  int                  mismatches = 0;
  int                  gap_left = 0;
  int                  burst_left = 0;
  int                  stall_phase = 0;

  task automatic queue_req(oqpm_pkg::in_item_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic expect_beat(oqpm_pkg::out_item_t b);
    expected_beats.insert(expected_beats.size(), b);
  endtask

  function automatic oqpm_pkg::out_item_t mk(oqpm_pkg::status_t s, int p, int m, bit l);
    oqpm_pkg::out_item_t r;
    r.status = s;
    r.position = p[5:0];
    r.moved_id = m[5:0];
    r.last = l;
    return r;
  endfunction

  function automatic int pos_of(int id);
    if (id_pos[id] < qlen) return id_pos[id];
    return DEPTH;
  endfunction

  task automatic apply_request(oqpm_pkg::in_item_t r);
    int id, p, t, lo, hi;
    int span_ids[DEPTH];
    id = int'(r.item_id);
    p = pos_of(id);
    t = int'(r.target_pos);
    case (r.req_type)
      oqpm_pkg::REQ_APPEND: begin
        if (p < qlen) expect_beat(mk(oqpm_pkg::ST_ALREADY, p, 0, 1));
        else if (qlen >= DEPTH) expect_beat(mk(oqpm_pkg::ST_FULL, DEPTH, 0, 1));
        else begin
          slot_ids[qlen] = id;
          id_pos[id] = qlen;
          expect_beat(mk(oqpm_pkg::ST_OK, qlen, 0, 1));
          qlen++;
        end
      end
      oqpm_pkg::REQ_QUERY: begin
        expect_beat(mk(p < qlen ? oqpm_pkg::ST_OK : oqpm_pkg::ST_NOT_QUEUED, p, 0, 1));
      end
      oqpm_pkg::REQ_REMOVE: begin
        if (p >= qlen) expect_beat(mk(oqpm_pkg::ST_NOT_QUEUED, DEPTH, 0, 1));
        else begin
          for (int i = p; i + 1 < qlen; i++) slot_ids[i] = slot_ids[i + 1];
          qlen--;
          id_pos[id] = DEPTH;
          for (int i = p; i < qlen; i++) id_pos[slot_ids[i]] = i;
          expect_beat(mk(oqpm_pkg::ST_OK, p, 0, 1));
        end
      end
      default: begin
        if (p >= qlen) expect_beat(mk(oqpm_pkg::ST_NOT_QUEUED, DEPTH, 0, 1));
        else begin
          if (t > qlen - 1) t = qlen - 1;
          if (t == p) expect_beat(mk(oqpm_pkg::ST_UNCHANGED, p, 0, 1));
          else begin
            lo = p < t ? p : t;
            hi = p < t ? t : p;
            for (int i = lo; i <= hi; i++) span_ids[i - lo] = slot_ids[i];
            if (p > t) for (int i = p; i > t; i--) slot_ids[i] = slot_ids[i - 1];
            else for (int i = p; i < t; i++) slot_ids[i] = slot_ids[i + 1];
            slot_ids[t] = id;
            for (int i = lo; i <= hi; i++) id_pos[slot_ids[i]] = i;
            for (int i = 0; i <= hi - lo; i++)
              expect_beat(mk(oqpm_pkg::ST_OK, id_pos[span_ids[i]], span_ids[i],
                             i == hi - lo));
          end
        end
      end
    endcase
  endtask

  function automatic oqpm_pkg::in_item_t req(oqpm_pkg::req_t k, int id, int t);
    oqpm_pkg::in_item_t r;
    r.req_type = k;
    r.item_id = id[5:0];
    r.target_pos = t[4:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        apply_request(in_data);
        void'(pending_reqs.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else burst_left <= burst_left - 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", out_data);
        end else begin
          oqpm_pkg::out_item_t e;
          e = expected_beats.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
          end
        end
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase[8]) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int id, pick;
    qlen = 0;
    for (int i = 0; i < IDS; i++) id_pos[i] = DEPTH;
    for (int i = 0; i < DEPTH; i++) slot_ids[i] = 0;
    // directed
    queue_req(req(oqpm_pkg::REQ_QUERY, 0, 0));
    queue_req(req(oqpm_pkg::REQ_REMOVE, 63, 0));
    queue_req(req(oqpm_pkg::REQ_MOVE, 5, 31));
    queue_req(req(oqpm_pkg::REQ_APPEND, 0, 0));
    queue_req(req(oqpm_pkg::REQ_APPEND, 63, 31));
    queue_req(req(oqpm_pkg::REQ_APPEND, 0, 0));
    queue_req(req(oqpm_pkg::REQ_APPEND, 21, 0));
    queue_req(req(oqpm_pkg::REQ_APPEND, 42, 0));
    queue_req(req(oqpm_pkg::REQ_QUERY, 63, 0));
    queue_req(req(oqpm_pkg::REQ_MOVE, 0, 31));
    queue_req(req(oqpm_pkg::REQ_MOVE, 0, 0));
    queue_req(req(oqpm_pkg::REQ_MOVE, 42, 1));
    queue_req(req(oqpm_pkg::REQ_MOVE, 42, 1));
    queue_req(req(oqpm_pkg::REQ_REMOVE, 21, 0));
    queue_req(req(oqpm_pkg::REQ_REMOVE, 21, 0));
    for (int i = 0; i < 33; i++) queue_req(req(oqpm_pkg::REQ_APPEND, i + 30, 0));
    queue_req(req(oqpm_pkg::REQ_MOVE, 30, 31));
    queue_req(req(oqpm_pkg::REQ_MOVE, 30, 0));
    queue_req(req(oqpm_pkg::REQ_REMOVE, 0, 0));
    // random: mostly ids from a small pool so hits are common
    for (int n = 0; n < 480; n++) begin
      pick = $urandom_range(0, 9);
      id = (pick < 8) ? $urandom_range(0, 39) : $urandom_range(0, 63);
      pick = $urandom_range(0, 9);
      queue_req(req(pick < 4 ? oqpm_pkg::REQ_APPEND : pick < 6 ? oqpm_pkg::REQ_REMOVE :
                    pick < 9 ? oqpm_pkg::REQ_MOVE : oqpm_pkg::REQ_QUERY,
                    id, $urandom_range(0, 31)));
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
